// ----- src/accel_integrator_peak_tracker_core_defines.svh -----
// Assertion macros shared by the accel integrator peak tracker RTL
`ifndef ACCEL_INTEGRATOR_PEAK_TRACKER_CORE_DEFINES_SVH
`define ACCEL_INTEGRATOR_PEAK_TRACKER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define AIPT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aipt assertion failed");

// Check that cons holds in the cycle after ante
`define AIPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aipt assertion failed");

`endif

// ----- src/aipt_pkg.sv -----
// Types, constants and helper functions of the accel integrator peak tracker
`timescale 1ns / 1ps
package aipt_pkg;

	localparam int ACC_W    = 16;
	localparam int DATA_W   = 32;
	localparam int PEAK_W   = 31;
	localparam int CNT_W    = 17;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OPA_W    = 33;
	localparam int OPB_W    = 32;
	localparam int PROD_W   = OPA_W + OPB_W;
	localparam int WIDE_W   = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEPS = 2'd1;

	localparam logic [CFG_W-1:0] TIME_STEP_RST    = 16'd655;
	localparam logic [CFG_W-1:0] WINDOW_STEPS_RST = 16'd100;

	// 2*pi in Q3.28, rounded to nearest
	localparam logic signed [OPB_W-1:0] TWO_PI_Q28 = 32'sd1686629713;

	localparam int VEL_SHIFT   = 1;
	localparam int DISP_SHIFT  = 17;
	localparam int FORCE_SHIFT = 28;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_V  = 8'b0000_0010,
		ST_ACC_V  = 8'b0000_0100,
		ST_PREP_D = 8'b0000_1000,
		ST_MUL_D  = 8'b0001_0000,
		ST_ACC_D  = 8'b0010_0000,
		ST_MUL_F  = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} aipt_state_t;

	typedef struct packed {
		logic                    en;
		logic signed [OPA_W-1:0] opa;
		logic signed [OPB_W-1:0] opb;
	} aipt_mul_req_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[WIDE_W-1:DATA_W-1];
		hi_zeros = ~|x[WIDE_W-1:DATA_W-1];
		if (hi_ones || hi_zeros) begin
			sat32 = x[DATA_W-1:0];
		end else if (x[WIDE_W-1]) begin
			sat32 = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat32 = {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

// ----- src/aipt_accel_if.sv -----
// Input channel carrying one acceleration sample per beat
`timescale 1ns / 1ps
interface aipt_accel_if;
	import aipt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ACC_W-1:0]  accel_sample;

	modport source (output valid, output accel_sample, input ready);
	modport sink (input valid, input accel_sample, output ready);
endinterface

// ----- src/aipt_result_if.sv -----
// Output channel carrying one integration result per beat
`timescale 1ns / 1ps
interface aipt_result_if;
	import aipt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] velocity_out;
	logic signed [DATA_W-1:0] displacement_out;
	logic [PEAK_W-1:0]        peak_out;
	logic                     window_done;
	logic signed [DATA_W-1:0] damping_force;

	modport source (output valid, output velocity_out, output displacement_out,
		output peak_out, output window_done, output damping_force, input ready);
	modport sink (input valid, input velocity_out, input displacement_out,
		input peak_out, input window_done, input damping_force, output ready);
endinterface

// ----- src/aipt_mul_unit.sv -----
// Shared signed multiplier with a registered product
`timescale 1ns / 1ps
module aipt_mul_unit
	import aipt_pkg::*;
(
	input  logic                     clk,
	input  aipt_mul_req_t            req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_s1 <= PROD_W'(req.opa) * PROD_W'(req.opb);
		end
	end

	assign prod = prod_s1;

endmodule

// ----- src/accel_integrator_peak_tracker_core.sv -----
// Top level of the accel integrator peak tracker: sequencer, accumulators, output register
//
// Usage:
//   in_ch carries one signed Q8.8 acceleration sample per beat. out_ch returns one
//   result per sample: velocity, displacement, peak displacement, a window-done flag
//   and the damping force, all Q8.24 but the flag and the unsigned Q7.24 peak.
//   cfg_we/cfg_index/cfg_wdata write time_step (index 0) and window_steps (index 1);
//   other indexes are ignored. Write them only while no sample is in flight.
// Timing:
//   A sample runs through three multiplies on one shared 33x32 multiplier, the first
//   two each followed by an accumulate step. The sequencer walks MUL_V, ACC_V, PREP_D,
//   MUL_D, ACC_D, MUL_F and FIN; the result is registered on leaving FIN and in_ch.ready
//   returns high in the same cycle, so the block takes no new sample until the last
//   one has left FIN.
// Reset:
//   arst_n clears the accumulators, peak, step count and out_ch.valid, returns the
//   sequencer to idle, and loads time_step = 655 and window_steps = 100.
// Backpressure:
//   The output register holds a result until out_ch.ready. A new sample is taken
//   meanwhile; its result waits in the final step until the register frees.
`timescale 1ns / 1ps
`include "accel_integrator_peak_tracker_core_defines.svh"
module accel_integrator_peak_tracker_core
	import aipt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	aipt_accel_if.sink            in_ch,
	aipt_result_if.source         out_ch
);

	aipt_state_t              state_q;
	logic [CFG_W-1:0]         time_step_q;
	logic [CFG_W-1:0]         window_steps_q;

	logic signed [ACC_W-1:0]  prev_accel_q;
	logic signed [DATA_W-1:0] vel_q;
	logic signed [DATA_W-1:0] vold_q;
	logic signed [DATA_W-1:0] disp_q;
	logic [PEAK_W-1:0]        peak_q;
	logic [CNT_W-1:0]         step_count_q;
	logic signed [OPA_W-1:0]  opa_q;
	logic signed [OPB_W-1:0]  opb_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_vel_q;
	logic signed [DATA_W-1:0] out_disp_q;
	logic [PEAK_W-1:0]        out_peak_q;
	logic                     out_done_q;
	logic signed [DATA_W-1:0] out_force_q;

	aipt_mul_req_t            mul_req;
	logic signed [PROD_W-1:0] prod;

	logic                     in_beat;
	logic                     fin_go;
	logic                     win_done;
	logic signed [WIDE_W-1:0] vel_sum;
	logic signed [WIDE_W-1:0] disp_sum;
	logic signed [WIDE_W-1:0] force_neg;
	logic signed [WIDE_W-1:0] force_w;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);
	assign win_done    = step_count_q > CNT_W'(window_steps_q);

	assign vel_sum   = WIDE_W'(vel_q) + WIDE_W'(prod >>> VEL_SHIFT);
	assign disp_sum  = WIDE_W'(disp_q) + WIDE_W'(prod >>> DISP_SHIFT);
	assign force_neg = -WIDE_W'(prod);
	assign force_w   = force_neg >>> FORCE_SHIFT;

	assign mul_req.en  = (state_q == ST_MUL_V) || (state_q == ST_MUL_D)
		|| (state_q == ST_MUL_F);
	assign mul_req.opa = opa_q;
	assign mul_req.opb = opb_q;

	aipt_mul_unit u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q    <= TIME_STEP_RST;
			window_steps_q <= WINDOW_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP:    time_step_q    <= cfg_wdata;
				REG_WINDOW_STEPS: window_steps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_accel_q <= '0;
			vel_q        <= '0;
			disp_q       <= '0;
			peak_q       <= '0;
			step_count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						prev_accel_q <= in_ch.accel_sample;
						state_q      <= ST_MUL_V;
					end
				end
				ST_MUL_V:  state_q <= ST_ACC_V;
				ST_ACC_V: begin
					vel_q   <= sat32(vel_sum);
					state_q <= ST_PREP_D;
				end
				ST_PREP_D: state_q <= ST_MUL_D;
				ST_MUL_D:  state_q <= ST_ACC_D;
				ST_ACC_D: begin
					disp_q  <= sat32(disp_sum);
					state_q <= ST_MUL_F;
				end
				ST_MUL_F: begin
					if (disp_q > $signed({1'b0, peak_q})) begin
						peak_q <= disp_q[PEAK_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						if (win_done) begin
							step_count_q <= '0;
							peak_q       <= '0;
						end else begin
							step_count_q <= step_count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand staging for the shared multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				opa_q  <= OPA_W'(in_ch.accel_sample) + OPA_W'(prev_accel_q);
				opb_q  <= OPB_W'({1'b0, time_step_q});
				vold_q <= vel_q;
			end
			ST_PREP_D: begin
				opa_q <= OPA_W'(vel_q) + OPA_W'(vold_q);
				opb_q <= OPB_W'({1'b0, time_step_q});
			end
			ST_ACC_D: begin
				opa_q <= OPA_W'(vel_q);
				opb_q <= TWO_PI_Q28;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_vel_q   <= vel_q;
			out_disp_q  <= disp_q;
			out_peak_q  <= peak_q;
			out_done_q  <= win_done;
			out_force_q <= sat32(force_w);
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.velocity_out     = out_vel_q;
	assign out_ch.displacement_out = out_disp_q;
	assign out_ch.peak_out         = out_peak_q;
	assign out_ch.window_done      = out_done_q;
	assign out_ch.damping_force    = out_force_q;

	`AIPT_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_q))
	`AIPT_ASSERT_NEXT(a_beat_starts_mul, in_beat, state_q == ST_MUL_V)
	`AIPT_ASSERT_NEXT(a_fin_loads_out, fin_go, out_valid_q && state_q == ST_IDLE)
	`AIPT_ASSERT_NEXT(a_window_clears, fin_go && win_done, peak_q == '0 && step_count_q == '0)

endmodule
